### sv/pee_pkg.sv
// Package for the prefix expression evaluator: constants, types, controller states.
// No dependencies.
`default_nettype none
package pee_pkg;
  localparam int unsigned StackDepthDef = 64;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;
  localparam logic [7:0] ChMod   = 8'h25;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PUSHNUM, ST_RD1, ST_RD2, ST_RD3, ST_CHECK, ST_ALU, ST_DIV,
    ST_WB, ST_RES, ST_OUT
  } pee_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // latch input beat and do char step
    logic push_num;  // push accumulator
    logic rd;        // issue stack read at count-1-rd_off
    logic [1:0] rd_off;
    logic cap_e, cap_d, cap_c; // capture read data
    logic alu;       // compute non-divide result / start divider
    logic div_step;
    logic wb;        // pop 3, push result
    logic res;       // build result
    logic clr;       // clear line state
  } pee_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_push; // char step needs number push
    logic last;
    logic cnt_ge3;
    logic foldable;
    logic is_div;
    logic div_done;
  } pee_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == ChPlus || c == ChMinus || c == ChMul || c == ChDiv || c == ChMod;
  endfunction
endpackage
`default_nettype wire

### sv/pee_ctrl.sv
// Controller FSM for the prefix expression evaluator.
// Depends on pee_pkg.
`default_nettype none
module pee_ctrl import pee_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire pee_sts_t sts_i,
  output pee_cmd_t      cmd_o
);
  pee_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ST_PUSHNUM;
        end
      end
      ST_PUSHNUM: begin
        if (sts_i.need_push) begin
          cmd_o.push_num = 1'b1;
          state_d = ST_RD1;
        end else if (sts_i.last) state_d = ST_RES;
        else state_d = ST_IDLE;
      end
      ST_RD1: begin
        if (sts_i.cnt_ge3) begin
          cmd_o.rd = 1'b1; cmd_o.rd_off = 2'd0; state_d = ST_RD2;
        end else if (sts_i.last) state_d = ST_RES;
        else state_d = ST_IDLE;
      end
      ST_RD2: begin
        cmd_o.cap_e = 1'b1; cmd_o.rd = 1'b1; cmd_o.rd_off = 2'd1; state_d = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.cap_d = 1'b1; cmd_o.rd = 1'b1; cmd_o.rd_off = 2'd2; state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.cap_c = 1'b1; state_d = ST_ALU;
      end
      ST_ALU: begin
        if (!sts_i.foldable) begin
          state_d = sts_i.last ? ST_RES : ST_IDLE;
        end else begin
          cmd_o.alu = 1'b1;
          state_d = sts_i.is_div ? ST_DIV : ST_WB;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1; state_d = ST_RD1;
      end
      ST_RES: begin
        cmd_o.res = 1'b1; state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clr = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### sv/pee_dp.sv
// Datapath for the prefix expression evaluator: stack memory, accumulator,
// ALU and a radix-2 divider. Depends on pee_pkg.
`default_nettype none
module pee_dp import pee_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  char_i,
  input  wire logic        last_i,
  input  wire pee_cmd_t    cmd_i,
  output pee_sts_t         sts_o,
  output logic [31:0]      value_o,
  output logic             legal_o
);
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  logic [32:0] mem [StackDepth];
  logic [32:0] rdata_q;
  logic [32:0] ent_e_q, ent_d_q, ent_c_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] acc_q;
  logic [7:0] prev_q, char_q;
  logic last_q, err_q, push_q;
  logic [31:0] res_q, value_q;
  logic legal_q;
  logic [31:0] bottom_q;   // entry 0 shadow
  logic bottom_num_q;
  // divider
  logic [31:0] dq_q, drem_q, dvs_q;
  logic [5:0] dcnt_q;
  logic dneg_q, rneg_q, dmod_q;

  wire full = (cnt_q == CW'(StackDepth));

  // push port
  logic        wr_en;
  logic [32:0] wr_data;
  logic [CW-1:0] wr_cnt;   // count before push
  always_comb begin
    wr_en = 1'b0; wr_data = '0; wr_cnt = cnt_q;
    if (cmd_i.take && is_op(char_i)) begin
      wr_en = 1'b1; wr_data = {25'd0, char_i};
    end else if (cmd_i.push_num) begin
      wr_en = 1'b1; wr_data = {1'b1, acc_q};
    end else if (cmd_i.wb) begin
      wr_en = 1'b1; wr_data = {1'b1, res_q}; wr_cnt = cnt_q - CW'(3);
    end
  end

  logic [CW-1:0] rd_idx;
  assign rd_idx = cnt_q - CW'(1) - CW'(cmd_i.rd_off);

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_cnt != CW'(StackDepth)) mem[wr_cnt[AW-1:0]] <= wr_data;
    if (cmd_i.rd) rdata_q <= mem[rd_idx[AW-1:0]];
  end

  // ALU and divider operands
  wire [31:0] a = ent_d_q[31:0];
  wire [31:0] b = ent_e_q[31:0];
  wire [7:0]  op = ent_c_q[7:0];
  wire [31:0] ma = a[31] ? -a : a;
  wire [31:0] mb = b[31] ? -b : b;
  wire [32:0] trial = {drem_q, dq_q[31]} - {1'b0, dvs_q};

  logic [31:0] alu_r;
  always_comb begin
    case (op)
      ChPlus:  alu_r = a + b;
      ChMinus: alu_r = a - b;
      ChMul:   alu_r = a * b;
      default: alu_r = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; acc_q <= '0; prev_q <= '0; err_q <= 1'b0;
      last_q <= 1'b0; char_q <= '0; push_q <= 1'b0;
      legal_q <= 1'b0; value_q <= '0; bottom_num_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        char_q <= char_i; last_q <= last_i; prev_q <= char_i;
        push_q <= (char_i == ChSpace && is_digit(prev_q)) || (last_i && is_digit(char_i));
        if (char_i == ChSpace) begin
          if (prev_q == 8'd0) err_q <= 1'b1;
        end else if (!is_op(char_i)) acc_q <= acc_q * 32'd10 + ({24'd0, char_i} - 32'd48);
        if (is_op(char_i)) begin
          if (full) err_q <= 1'b1; else cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.push_num) begin
        acc_q <= '0;
        if (full) err_q <= 1'b1; else cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.wb) begin
        cnt_q <= cnt_q - CW'(2);
        if (cmd_i.wb && (op == ChDiv || op == ChMod) && b == 32'd0) err_q <= 1'b1;
      end
      if (cmd_i.res) begin
        legal_q <= !err_q && cnt_q == CW'(1) && bottom_num_q;
        value_q <= (!err_q && cnt_q == CW'(1) && bottom_num_q) ? bottom_q : 32'd0;
      end
      if (wr_en && wr_cnt == CW'(0)) bottom_num_q <= wr_data[32];
      if (cmd_i.clr) begin
        cnt_q <= '0; acc_q <= '0; prev_q <= '0; err_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_cnt == CW'(0)) bottom_q <= wr_data[31:0];
    if (cmd_i.cap_e) ent_e_q <= rdata_q;
    if (cmd_i.cap_d) ent_d_q <= rdata_q;
    if (cmd_i.cap_c) ent_c_q <= rdata_q;
    if (cmd_i.alu) begin
      res_q <= alu_r;
      dq_q <= ma; drem_q <= '0; dvs_q <= mb; dcnt_q <= '0;
      dneg_q <= a[31] ^ b[31]; rneg_q <= a[31]; dmod_q <= (op == ChMod);
    end
    if (cmd_i.div_step) begin
      if (dcnt_q == 6'd32) begin
        if (dvs_q == 32'd0) res_q <= '0;
        else if (dmod_q) res_q <= rneg_q ? -drem_q : drem_q;
        else res_q <= dneg_q ? -dq_q : dq_q;
      end else begin
        dcnt_q <= dcnt_q + 6'd1;
        if (!trial[32]) begin
          drem_q <= trial[31:0]; dq_q <= {dq_q[30:0], 1'b1};
        end else begin
          drem_q <= {drem_q[30:0], dq_q[31]}; dq_q <= {dq_q[30:0], 1'b0};
        end
      end
    end
  end

  assign sts_o.need_push = push_q;
  assign sts_o.last      = last_q;
  assign sts_o.cnt_ge3   = cnt_q >= CW'(3);
  assign sts_o.foldable  = !ent_c_q[32] && ent_d_q[32] && ent_e_q[32];
  assign sts_o.is_div    = (op == ChDiv) || (op == ChMod);
  assign sts_o.div_done  = dcnt_q == 6'd32;
  assign value_o = value_q;
  assign legal_o = legal_q;

  // char_q and the upper bits of an operator entry carry nothing
  logic unused;
  assign unused = ^{char_q, ent_c_q[31:8]};
endmodule
`default_nettype wire

### sv/prefix_expression_evaluator.sv
// Prefix expression evaluator top: one character per input beat, one result beat
// per line. A character that ends a number pushes it; the stack top is then read
// three entries deep and folded while it can, each fold by the ALU and write-back,
// with the one-bit-per-cycle divider for / and %. Line end holds the result through
// output stall. One beat is worked on at a time. Reset (rst_ni low, async) clears
// line state; stack contents stay undefined and are never read before written.
// Depends on pee_pkg, pee_ctrl, pee_dp.
`default_nettype none
module prefix_expression_evaluator import pee_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // line_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] value
  output logic             m_axis_tuser    // legal
);
  pee_cmd_t cmd;
  pee_sts_t sts;

  pee_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pee_dp #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni,
    .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .cmd_i(cmd), .sts_o(sts),
    .value_o(m_axis_tdata), .legal_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

### sv/pee_checker.sv
// Port-level checker for the prefix expression evaluator, bound to the top.
// Depends on nothing but the top level's ports.
`default_nettype none
module pee_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == 32'd0) else $error("bad illegal value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("took two beats");
endmodule

bind prefix_expression_evaluator pee_checker u_chk (.*);
`default_nettype wire
